// ----- src/box_blur_3x3_rgb_assert.svh -----
// Assertion macros shared by the blur RTL.
// Both sample on the rising edge of clk and are switched off while rst is high.
`ifndef BOX_BLUR_3X3_RGB_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBLUR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBLUR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/bblur_pkg.sv -----
`default_nettype none

package bblur_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_WIDTH_DEFAULT = 1024;
  localparam int FRAC_BITS_DEFAULT = 12;

  // Pixel and arithmetic widths.
  localparam int CHAN_W   = 8;
  localparam int NUM_CH   = 3;
  localparam int SUM_W    = 12;  // nine 8-bit values
  localparam int FACTOR_W = 16;
  localparam int PROD_W   = SUM_W + FACTOR_W;
  localparam int WINDOW_DEPTH = 6;

  // Register file.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_WIDTH_W = 11;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_WEIGHT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 1'd1;
  localparam logic [FACTOR_W-1:0]    KERNEL_WEIGHT_RESET = 16'd455;
  localparam logic [CFG_WIDTH_W-1:0] IMAGE_WIDTH_RESET   = 11'd1024;

  // Scan geometry.
  localparam int MIN_WIDTH = 3;
  localparam int BORDER    = 2;  // first column and row that completes a window
  localparam int POS_W     = 10;
  localparam logic [POS_W-1:0] ROW_MAX = 10'd1023;

  localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'hFF;
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef logic [CHAN_W-1:0] chan_t;

  // Element 0 is red, 1 is green, 2 is blue.
  typedef chan_t [NUM_CH-1:0] rgb_t;

  typedef struct packed {
    rgb_t upper;
    rgb_t middle;
  } line_pair_t;

  // Position and emit flag of a word in flight.
  typedef struct packed {
    logic             emit;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
  } pos_t;

endpackage

`default_nettype wire

// ----- src/bblur_scan.sv -----
`default_nettype none

module bblur_scan #(
  parameter int MAX_WIDTH = bblur_pkg::MAX_WIDTH_DEFAULT,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 accept,
  input  wire logic                                 frame_start,
  input  wire logic [bblur_pkg::CFG_WIDTH_W-1:0]    image_width,
  output logic      [COL_W-1:0]                     col,
  output bblur_pkg::pos_t                           pos
);
  import bblur_pkg::*;

  localparam int CMP_W = (COL_W + 1 > CFG_WIDTH_W) ? COL_W + 1 : CFG_WIDTH_W;
  localparam int XW    = (COL_W > POS_W) ? COL_W : POS_W;

  logic [COL_W-1:0] column_count, column_count_next, count_cur;
  logic [POS_W-1:0] row_count, row_count_next, row_cur;
  logic [CMP_W-1:0] width_raw, width_eff, col_plus;
  logic [XW-1:0]    col_minus;
  logic             row_last;

  always_comb begin
    // A frame start makes this word pixel (0,0).
    count_cur = frame_start ? '0 : column_count;
    row_cur   = frame_start ? '0 : row_count;

    width_raw = CMP_W'(image_width);
    if (width_raw < CMP_W'(MIN_WIDTH)) begin
      width_eff = CMP_W'(MIN_WIDTH);
    end else if (width_raw > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = width_raw;
    end

    col_plus = CMP_W'(count_cur) + CMP_W'(1);
    row_last = (col_plus >= width_eff);

    column_count_next = row_last ? '0 : col_plus[COL_W-1:0];
    row_count_next    = (row_last && (row_cur != ROW_MAX)) ? row_cur + POS_W'(1) : row_cur;

    col_minus  = XW'(count_cur) - XW'(1);
    col        = count_cur;
    pos.emit   = (CMP_W'(count_cur) >= CMP_W'(BORDER)) && (row_cur >= POS_W'(BORDER));
    pos.column = col_minus[POS_W-1:0];
    pos.row    = row_cur - POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/bblur_line_buf.sv -----
`default_nettype none

module bblur_line_buf #(
  parameter int MAX_WIDTH = bblur_pkg::MAX_WIDTH_DEFAULT,
  localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
  input  wire logic                   clk,
  input  wire logic                   rd_en,
  input  wire logic [ADDR_W-1:0]      rd_addr,
  input  wire logic                   wr_en,
  input  wire logic [ADDR_W-1:0]      wr_addr,
  input  wire bblur_pkg::line_pair_t  wr_data,
  output bblur_pkg::line_pair_t       rd_data
);
  import bblur_pkg::*;

  // Upper and middle line share one entry per column.
  line_pair_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read of the column being written in the same cycle sees the new entry.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/bblur_kernel.sv -----
`default_nettype none

module bblur_kernel #(
  parameter int FACTOR_FRAC_BITS = bblur_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          shift,
  input  wire bblur_pkg::rgb_t               upper,
  input  wire bblur_pkg::rgb_t               middle,
  input  wire bblur_pkg::rgb_t               pixel,
  input  wire logic [bblur_pkg::FACTOR_W-1:0] weight,
  output bblur_pkg::rgb_t                    result
);
  import bblur_pkg::*;

  // Two older columns, each upper, middle, current row.
  rgb_t window_columns [WINDOW_DEPTH];

  logic [SUM_W-1:0]  sum     [NUM_CH];
  logic [PROD_W-1:0] product [NUM_CH];
  logic [PROD_W-1:0] scaled  [NUM_CH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        window_columns[i] <= '0;
      end
    end else if (shift) begin
      window_columns[0] <= window_columns[3];
      window_columns[1] <= window_columns[4];
      window_columns[2] <= window_columns[5];
      window_columns[3] <= upper;
      window_columns[4] <= middle;
      window_columns[5] <= pixel;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sum[c] = SUM_W'(upper[c]) + SUM_W'(middle[c]) + SUM_W'(pixel[c]);
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        sum[c] = sum[c] + SUM_W'(window_columns[i][c]);
      end
      product[c] = PROD_W'(sum[c]) * PROD_W'(weight);
      scaled[c]  = product[c] >> FACTOR_FRAC_BITS;
      result[c]  = (|scaled[c][PROD_W-1:CHAN_W]) ? CHAN_MAX : scaled[c][CHAN_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- src/box_blur_3x3_rgb.sv -----
`default_nettype none

// 3x3 box blur over an RGB pixel stream in raster order. The block takes one
// pixel word per clock and returns at most one result word per clock, so it
// sustains one pixel per cycle while its output is not stalled; a result
// passes from the input register to the output register and leaves from
// there. The edge that takes a pixel into the input register also reads
// the two stored lines of its column from a single memory (one read and
// one write port, with bypass for the column being written); in the
// following cycle the kernel sums the nine neighbors, scales by the
// kernel weight (unsigned, FACTOR_FRAC_BITS fraction bits, truncated) and
// clamps to 255. A word that completes a window, that is one at column and
// row of at least two, yields the blurred pixel one column to the left and
// one row up; border pixels give no result. frame_start marks the first pixel
// of an image and restarts the position counters. The line memory is not
// cleared, so no startup pass is needed: every entry that feeds a result has
// been written earlier in the same frame, as long as the width does not grow
// within a frame. The block stalls its input only while the word in its
// input register would give a result and the output register still holds
// one that is not taken. Write the kernel weight and image_width only while
// the block is idle.
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH        = bblur_pkg::MAX_WIDTH_DEFAULT,
  parameter int FACTOR_FRAC_BITS = bblur_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Configuration port.
  input  wire logic                               cfg_write,
  input  wire logic [bblur_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [bblur_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Pixel input channel.
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [bblur_pkg::CHAN_W-1:0]       red_in,
  input  wire logic [bblur_pkg::CHAN_W-1:0]       green_in,
  input  wire logic [bblur_pkg::CHAN_W-1:0]       blue_in,
  input  wire logic                               frame_start,
  // Result channel.
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [bblur_pkg::CHAN_W-1:0]       red_out,
  output logic      [bblur_pkg::CHAN_W-1:0]       green_out,
  output logic      [bblur_pkg::CHAN_W-1:0]       blue_out,
  output logic      [bblur_pkg::CHAN_W-1:0]       alpha_out,
  output logic      [bblur_pkg::POS_W-1:0]        out_column,
  output logic      [bblur_pkg::POS_W-1:0]        out_row
);
  import bblur_pkg::*;

`include "box_blur_3x3_rgb_assert.svh"

  localparam int COL_W = $clog2(MAX_WIDTH);

  // Configuration registers.
  logic [FACTOR_W-1:0]    kernel_weight;
  logic [CFG_WIDTH_W-1:0] image_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_weight <= KERNEL_WEIGHT_RESET;
      image_width   <= IMAGE_WIDTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KERNEL_WEIGHT: kernel_weight <= cfg_data[FACTOR_W-1:0];
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[CFG_WIDTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake and flow control. The working stage moves on when it is
  // empty-handed for the output or the output register can take its result.
  logic in_accept;
  logic out_free;
  logic s1_advance;
  logic s1_load_out;

  logic             s1_valid;
  rgb_t             s1_pixel;
  pos_t             s1_pos;
  logic [COL_W-1:0] s1_col;

  assign in_accept   = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign s1_advance  = s1_valid && (!s1_pos.emit || out_free);
  assign s1_load_out = s1_advance && s1_pos.emit;
  assign in_stall    = s1_valid && !s1_advance;

  // Position of the incoming word.
  logic [COL_W-1:0] scan_col;
  pos_t             scan_pos;

  bblur_scan #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .frame_start(frame_start),
    .image_width(image_width),
    .col        (scan_col),
    .pos        (scan_pos)
  );

  // Input register.
  rgb_t in_pixel;
  assign in_pixel[0] = red_in;
  assign in_pixel[1] = green_in;
  assign in_pixel[2] = blue_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pixel <= in_pixel;
      s1_pos   <= scan_pos;
      s1_col   <= scan_col;
    end
  end

  // Line memory: read as the word enters, written back as it leaves, with
  // the middle line moving up and the new pixel becoming the middle line.
  line_pair_t line_rd;
  line_pair_t line_wr;

  assign line_wr.upper  = line_rd.middle;
  assign line_wr.middle = s1_pixel;

  bblur_line_buf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_buf (
    .clk    (clk),
    .rd_en  (in_accept),
    .rd_addr(scan_col),
    .wr_en  (s1_advance),
    .wr_addr(s1_col),
    .wr_data(line_wr),
    .rd_data(line_rd)
  );

  // Window and arithmetic.
  rgb_t blurred;

  bblur_kernel #(
    .FACTOR_FRAC_BITS(FACTOR_FRAC_BITS)
  ) u_kernel (
    .clk   (clk),
    .rst   (rst),
    .shift (s1_advance),
    .upper (line_rd.upper),
    .middle(line_rd.middle),
    .pixel (s1_pixel),
    .weight(kernel_weight),
    .result(blurred)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load_out) begin
      red_out    <= blurred[0];
      green_out  <= blurred[1];
      blue_out   <= blurred[2];
      out_column <= s1_pos.column;
      out_row    <= s1_pos.row;
    end
  end

  assign alpha_out = ALPHA_OPAQUE;

  // A result that finds the output register holding a word not taken must hold the input.
  `BBLUR_ASSERT_NOW(a_hold_input, s1_valid && s1_pos.emit && !out_free, in_stall, "input ran on")

  // A result leaving the working stage shows up at the output.
  `BBLUR_ASSERT_NEXT(a_result_lands, s1_load_out, out_valid, "result word lost between stages")

  // An accepted word occupies the working stage on the next cycle.
  `BBLUR_ASSERT_NEXT(a_word_lands, in_accept, s1_valid, "accepted word lost")

  // Emitted rows are interior rows.
  `BBLUR_ASSERT_NOW(a_row_interior, out_valid, out_row != '0, "border row emitted")

endmodule

`default_nettype wire
